### design/dvrt_pkg.sv
// shared types and constants for the distance-vector route table
`timescale 1ns / 1ps

package dvrt_pkg;

   // default sizes handed to the top level
   localparam int DEF_TABLE_ROWS   = 64;
   localparam int DEF_ADDRESS_BITS = 16;

   // fixed field widths
   localparam int DELAY_IN_BITS  = 16;
   localparam int ROW_DELAY_BITS = 17;
   localparam int FUNC_BITS      = 2;
   localparam int KIND_BITS      = 2;

   // item function carried in the request tuser
   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_HEADER = 2'd0,
      FUNC_ENTRY  = 2'd1,
      FUNC_LOOKUP = 2'd2,
      FUNC_RSVD   = 2'd3
   } func_type;

   // result kind carried in the response tuser
   typedef enum logic [KIND_BITS-1:0] {
      KIND_ACK   = 2'd0,
      KIND_FOUND = 2'd1,
      KIND_NONE  = 2'd2
   } kind_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_UPDATE,
      ST_RESULT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;    // latch the accepted word and reset the scan
      logic step;    // read one row and advance the scan index
      logic update;  // write back, insert or flag overflow
      logic emit;    // load the response register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      func_type in_func;    // function of the word on the request port
      logic     in_last;
      logic     in_own;     // request address equals own address
      logic     tbl_empty;
      logic     scan_last;  // the row being read now is the last valid one
      func_type item_func;  // function of the latched word
      logic     item_last;
      logic     out_free;   // response register can take a new word
   } status_type;

endpackage

### design/dvrt_ctrl.sv
// controller state machine sequencing scan, update and response
`timescale 1ns / 1ps

module dvrt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  dvrt_pkg::status_type status,
   output dvrt_pkg::cmd_type    cmd
);
   import dvrt_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               priority if (status.in_func == FUNC_RSVD) begin
                  state_in = ST_IDLE;
               end else if (status.in_func == FUNC_ENTRY && status.in_own) begin
                  state_in = status.in_last ? ST_RESULT : ST_IDLE;
               end else if (status.tbl_empty) begin
                  state_in = ST_UPDATE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (status.item_func == FUNC_LOOKUP || status.item_last) begin
               state_in = ST_RESULT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_RESULT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_SCAN: begin
            cmd.step = 1'b1;
         end
         ST_DRAIN: begin
            cmd = '0;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
         end
         ST_RESULT: begin
            cmd.emit = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

### design/dvrt_datapath.sv
// route memory, scan compare, table update and response register
`timescale 1ns / 1ps

module dvrt_datapath #(
   parameter int TABLE_ROWS   = dvrt_pkg::DEF_TABLE_ROWS,
   parameter int ADDRESS_BITS = dvrt_pkg::DEF_ADDRESS_BITS,
   parameter int REQ_BITS     = 32,
   parameter int RSP_BITS     = 40
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [REQ_BITS-1:0]            req_tdata,
   input  logic [dvrt_pkg::FUNC_BITS-1:0] req_tuser,
   input  logic                           req_tlast,
   output logic [RSP_BITS-1:0]            rsp_tdata,
   output logic [dvrt_pkg::KIND_BITS-1:0] rsp_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ADDRESS_BITS-1:0]        csr_data,
   input  dvrt_pkg::cmd_type              cmd,
   output dvrt_pkg::status_type           status
);
   import dvrt_pkg::*;

   localparam int ROW_BITS = $clog2(TABLE_ROWS);
   localparam int CNT_BITS = $clog2(TABLE_ROWS + 1);
   localparam int MEM_BITS = 2 * ADDRESS_BITS + ROW_DELAY_BITS;

   // route memory: destination, gateway, delay from the top bit down
   logic [MEM_BITS-1:0] mem [TABLE_ROWS];

   logic [ADDRESS_BITS-1:0]   own_ff;
   logic [CNT_BITS-1:0]       count_ff;
   logic [ADDRESS_BITS-1:0]   cur_gw_ff;
   logic [DELAY_IN_BITS-1:0]  cur_link_ff;
   logic                      ovf_ff;
   func_type                  item_func_ff;
   logic [ADDRESS_BITS-1:0]   item_addr_ff;
   logic                      item_last_ff;
   logic [ROW_DELAY_BITS-1:0] total_ff;
   logic [CNT_BITS-1:0]       idx_ff;
   logic [ROW_BITS-1:0]       rd_idx_ff;
   logic [MEM_BITS-1:0]       rd_data_ff;
   logic                      cmp_valid_ff;
   logic                      found_ff;
   logic [ROW_BITS-1:0]       match_idx_ff;
   logic [ADDRESS_BITS-1:0]   match_dest_ff;
   logic [ADDRESS_BITS-1:0]   best_gw_ff;
   logic [ROW_DELAY_BITS-1:0] best_dly_ff;
   logic                      rsp_valid_ff;
   kind_type                  rsp_kind_ff;
   logic [RSP_BITS-1:0]       rsp_data_ff;

   func_type                  in_func;
   logic [ADDRESS_BITS-1:0]   in_addr;
   logic [DELAY_IN_BITS-1:0]  in_dly;
   logic [ADDRESS_BITS-1:0]   row_dest;
   logic [ADDRESS_BITS-1:0]   row_gw;
   logic [ROW_DELAY_BITS-1:0] row_dly;
   logic                      hit;
   logic                      tbl_full;
   logic                      is_route_item;
   logic                      wr_en;
   logic [ROW_BITS-1:0]       wr_addr;
   logic [MEM_BITS-1:0]       wr_data;
   logic                      out_free;
   logic                      emit_ack;
   kind_type                  res_kind;
   logic [ADDRESS_BITS-1:0]   res_gw;
   logic [ROW_DELAY_BITS-1:0] res_dly;
   logic                      res_ovf;

   // request word fields
   assign in_func = func_type'(req_tuser);
   assign in_addr = req_tdata[ADDRESS_BITS-1:0];
   assign in_dly  = req_tdata[ADDRESS_BITS +: DELAY_IN_BITS];

   // row read back from memory
   assign row_dly  = rd_data_ff[ROW_DELAY_BITS-1:0];
   assign row_gw   = rd_data_ff[ROW_DELAY_BITS +: ADDRESS_BITS];
   assign row_dest = rd_data_ff[ROW_DELAY_BITS + ADDRESS_BITS +: ADDRESS_BITS];

   assign tbl_full      = (count_ff == CNT_BITS'(TABLE_ROWS));
   assign is_route_item = (item_func_ff == FUNC_HEADER) || (item_func_ff == FUNC_ENTRY);
   assign out_free      = !rsp_valid_ff || rsp_tready;

   // own address register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         own_ff <= '0;
      end else if (csr_valid) begin
         own_ff <= csr_data;
      end
   end

   // match condition for the row being compared
   always_comb begin
      hit = 1'b0;
      if (cmp_valid_ff) begin
         unique case (item_func_ff)
            FUNC_HEADER: hit = (row_gw == cur_gw_ff);
            FUNC_ENTRY:  hit = (row_dest == item_addr_ff) && (row_gw == cur_gw_ff);
            FUNC_LOOKUP: hit = (row_dest == item_addr_ff);
            default:     hit = 1'b0;
         endcase
      end
   end

   // latched item, packet context and delay sum
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_gw_ff   <= '0;
         cur_link_ff <= '0;
      end else if (cmd.load && in_func == FUNC_HEADER) begin
         cur_gw_ff   <= in_addr;
         cur_link_ff <= in_dly;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_func_ff <= in_func;
         item_addr_ff <= in_addr;
         item_last_ff <= req_tlast;
         if (in_func == FUNC_HEADER) begin
            total_ff <= ROW_DELAY_BITS'(in_dly);
         end else begin
            total_ff <= ROW_DELAY_BITS'(cur_link_ff) + ROW_DELAY_BITS'(in_dly);
         end
      end
   end

   // scan index and registered memory read
   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_valid_ff <= 1'b0;
      end else begin
         cmp_valid_ff <= cmd.step;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         idx_ff <= '0;
      end else if (cmd.step) begin
         idx_ff <= idx_ff + CNT_BITS'(1);
      end
      if (cmd.step) begin
         rd_idx_ff <= idx_ff[ROW_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         rd_data_ff <= mem[idx_ff[ROW_BITS-1:0]];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // first match for route items, minimum delay for lookups
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (cmd.load) begin
         found_ff <= 1'b0;
      end else if (hit) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (hit) begin
         if (item_func_ff == FUNC_LOOKUP) begin
            if (!found_ff || row_dly < best_dly_ff) begin
               best_gw_ff  <= row_gw;
               best_dly_ff <= row_dly;
            end
         end else if (!found_ff) begin
            match_idx_ff  <= rd_idx_ff;
            match_dest_ff <= row_dest;
            best_gw_ff    <= row_gw;
         end
      end
   end

   // write back a matched row or insert a new one
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = count_ff[ROW_BITS-1:0];
      wr_data = {item_addr_ff, cur_gw_ff, total_ff};
      if (cmd.update && is_route_item) begin
         if (found_ff) begin
            wr_en   = 1'b1;
            wr_addr = match_idx_ff;
            wr_data = {match_dest_ff, best_gw_ff, total_ff};
         end else if (!tbl_full) begin
            wr_en = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.update && is_route_item && !found_ff && !tbl_full) begin
         count_ff <= count_ff + CNT_BITS'(1);
      end
   end

   // overflow flag, set on a dropped row, cleared when acknowledged
   assign emit_ack = cmd.emit && item_func_ff != FUNC_LOOKUP;
   always_ff @(posedge clock) begin
      if (reset) begin
         ovf_ff <= 1'b0;
      end else if (cmd.update && is_route_item && !found_ff && tbl_full) begin
         ovf_ff <= 1'b1;
      end else if (emit_ack) begin
         ovf_ff <= 1'b0;
      end
   end

   // response word
   always_comb begin
      res_kind = KIND_ACK;
      res_gw   = '0;
      res_dly  = '0;
      res_ovf  = ovf_ff;
      if (item_func_ff == FUNC_LOOKUP) begin
         res_ovf = 1'b0;
         if (found_ff) begin
            res_kind = KIND_FOUND;
            res_gw   = best_gw_ff;
            res_dly  = best_dly_ff;
         end else begin
            res_kind = KIND_NONE;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_kind_ff <= res_kind;
         rsp_data_ff <= RSP_BITS'({res_ovf, res_dly, res_gw});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = rsp_data_ff;

   // status to the controller
   always_comb begin
      status.in_func   = in_func;
      status.in_last   = req_tlast;
      status.in_own    = (in_addr == own_ff);
      status.tbl_empty = (count_ff == '0);
      status.scan_last = ((idx_ff + CNT_BITS'(1)) == count_ff);
      status.item_func = item_func_ff;
      status.item_last = item_last_ff;
      status.out_free  = out_free;
   end

endmodule

### design/distance_vector_route_table.sv
// top level of the distance-vector route table
`timescale 1ns / 1ps

// Route table holding up to TABLE_ROWS routes (destination, gateway, delay)
// in a single-port-write, registered-read memory. Header, entry and lookup
// words are handled by a scan that reads one row per cycle through that
// memory port. A word that gives a response is accepted, the valid rows are
// read, the last compare is finished, a header or entry row is written back
// or inserted, and the response register is loaded. A word without a
// response skips the response load. With an empty table the read and
// compare steps are skipped. Words with the unused function code are
// accepted and dropped without a scan, and an entry naming the own address
// skips the scan and goes straight to the response load when it closes a
// packet. The response register lets a finished result wait while the next
// word is accepted; a second result waits in the controller until that
// register is taken. The table needs no clearing after reset: only rows
// below the row count are ever read. The own address is written over the csr
// channel while the block is idle; the user is bound to this, the block does not enforce it.

module distance_vector_route_table #(
   parameter int TABLE_ROWS   = dvrt_pkg::DEF_TABLE_ROWS,
   parameter int ADDRESS_BITS = dvrt_pkg::DEF_ADDRESS_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   // address, then delay_value
   input  logic [((ADDRESS_BITS + dvrt_pkg::DELAY_IN_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // func
   input  logic [dvrt_pkg::FUNC_BITS-1:0] req_tuser,
   input  logic                           req_tlast,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // route_gateway, then route_delay, then overflow
   output logic [((ADDRESS_BITS + dvrt_pkg::ROW_DELAY_BITS + 8) / 8) * 8 - 1:0] rsp_tdata,
   // kind
   output logic [dvrt_pkg::KIND_BITS-1:0] rsp_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ADDRESS_BITS-1:0]        csr_data
);
   import dvrt_pkg::*;

   localparam int REQ_BITS = ((ADDRESS_BITS + DELAY_IN_BITS + 7) / 8) * 8;
   localparam int RSP_BITS = ((ADDRESS_BITS + ROW_DELAY_BITS + 8) / 8) * 8;

   cmd_type    cmd;
   status_type status;

   // sequencing
   dvrt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // table and response datapath
   dvrt_datapath #(
      .TABLE_ROWS   (TABLE_ROWS),
      .ADDRESS_BITS (ADDRESS_BITS),
      .REQ_BITS     (REQ_BITS),
      .RSP_BITS     (RSP_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

### test/distance_vector_route_table_tb.sv
// self-checking testbench for the distance-vector route table
`timescale 1ns / 1ps

module distance_vector_route_table_tb;
   import dvrt_pkg::*;

   localparam int ROWS  = DEF_TABLE_ROWS;
   localparam int ABITS = DEF_ADDRESS_BITS;
   localparam int REQ_W = ((ABITS + DELAY_IN_BITS + 7) / 8) * 8;
   localparam int RSP_W = ((ABITS + ROW_DELAY_BITS + 8) / 8) * 8;
   // a full-table scan plus write-back and response load, with margin
   localparam int SETTLE_CYCLES   = ROWS + 16;
   localparam int HOLD_OFF_CYCLES = 400;

   logic                  clock;
   logic                  reset;
   logic [REQ_W-1:0]      req_tdata;
   logic [FUNC_BITS-1:0]  req_tuser;
   logic                  req_tlast;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [RSP_W-1:0]      rsp_tdata;
   logic [KIND_BITS-1:0]  rsp_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [ABITS-1:0]      csr_data;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_cycles    = 0;
   int words_sent     = 0;
   logic [ABITS-1:0] addr_pool [16];

   typedef struct {
      kind_type                kind;
      logic [ABITS-1:0]        gateway;
      logic [ROW_DELAY_BITS-1:0] total;
      logic                    ovf;
   } reply_type;

   // route table mirror and queue of replies still owed by the block
   class route_table_model_type;
      logic [ABITS-1:0]          own_addr;
      int unsigned               rows;
      logic [ABITS-1:0]          row_dest [ROWS];
      logic [ABITS-1:0]          row_gw [ROWS];
      logic [ROW_DELAY_BITS-1:0] row_dly [ROWS];
      logic [ABITS-1:0]          cur_gw;
      logic [DELAY_IN_BITS-1:0]  cur_link;
      logic                      ovf_pending;
      reply_type                 expected_replies[$];
      int                        mismatch_count;

      function new();
         own_addr       = '0;
         rows           = 0;
         cur_gw         = '0;
         cur_link       = '0;
         ovf_pending    = 1'b0;
         mismatch_count = 0;
      endfunction

      function int pending();
         return expected_replies.size();
      endfunction

      task report_mismatch(string msg);
         if (mismatch_count < 50)
            $display("mismatch at %0t ns: %s", $time, msg);
         mismatch_count++;
      endtask

      // insert a row, or drop it and flag overflow when the table is full
      function void add_route(logic [ABITS-1:0] dest, logic [ABITS-1:0] gw,
                              logic [ROW_DELAY_BITS-1:0] dly);
         if (rows >= ROWS) begin
            ovf_pending = 1'b1;
         end else begin
            row_dest[rows] = dest;
            row_gw[rows]   = gw;
            row_dly[rows]  = dly;
            rows++;
         end
      endfunction

      // update the table for one accepted word and queue any reply it owes
      function void note_word(func_type f, logic [ABITS-1:0] a,
                              logic [DELAY_IN_BITS-1:0] d, logic last);
         logic [ROW_DELAY_BITS-1:0] total;
         logic [ROW_DELAY_BITS-1:0] best_dly;
         logic [ABITS-1:0]          best_gw;
         bit                        hit;
         reply_type                 r;
         hit      = 0;
         best_dly = '0;
         best_gw  = '0;
         case (f)
            FUNC_HEADER: begin
               cur_gw   = a;
               cur_link = d;
               for (int i = 0; i < rows && !hit; i++)
                  if (row_gw[i] == a) begin
                     row_dly[i] = {1'b0, d};
                     hit = 1;
                  end
               if (!hit)
                  add_route(a, a, {1'b0, d});
            end
            FUNC_ENTRY: begin
               total = {1'b0, cur_link} + {1'b0, d};
               if (a != own_addr) begin
                  for (int i = 0; i < rows && !hit; i++)
                     if (row_dest[i] == a && row_gw[i] == cur_gw) begin
                        row_dly[i] = total;
                        hit = 1;
                     end
                  if (!hit)
                     add_route(a, cur_gw, total);
               end
            end
            FUNC_LOOKUP: begin
               // minimum delay, lowest row wins a tie
               for (int i = 0; i < rows; i++)
                  if (row_dest[i] == a && (!hit || row_dly[i] < best_dly)) begin
                     hit      = 1;
                     best_gw  = row_gw[i];
                     best_dly = row_dly[i];
                  end
               r.kind    = hit ? KIND_FOUND : KIND_NONE;
               r.gateway = best_gw;
               r.total   = best_dly;
               r.ovf     = 1'b0;
               expected_replies.insert(expected_replies.size(), r);
            end
            default: ;
         endcase
         // acknowledge closes a routing packet
         if ((f == FUNC_HEADER || f == FUNC_ENTRY) && last) begin
            r.kind    = KIND_ACK;
            r.gateway = '0;
            r.total   = '0;
            r.ovf     = ovf_pending;
            ovf_pending = 1'b0;
            expected_replies.insert(expected_replies.size(), r);
         end
      endfunction

      task check_word(kind_type k, logic [ABITS-1:0] gw,
                      logic [ROW_DELAY_BITS-1:0] dly, logic ovf);
         reply_type r;
         if (expected_replies.size() == 0) begin
            report_mismatch($sformatf("unexpected reply kind %0d", k));
         end else begin
            r = expected_replies.pop_front();
            if (r.kind !== k)
               report_mismatch($sformatf("kind %0d, want %0d", k, r.kind));
            if (r.gateway !== gw)
               report_mismatch($sformatf("gateway %h, want %h", gw, r.gateway));
            if (r.total !== dly)
               report_mismatch($sformatf("delay %h, want %h", dly, r.total));
            if (r.ovf !== ovf)
               report_mismatch($sformatf("overflow %b, want %b", ovf, r.ovf));
         end
      endtask
   endclass

   route_table_model_type store = new();

   distance_vector_route_table #(
      .TABLE_ROWS  (ROWS),
      .ADDRESS_BITS(ABITS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tlast (req_tlast),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // check every reply word taken from the block
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         store.check_word(kind_type'(rsp_tuser), rsp_tdata[ABITS-1:0],
                          rsp_tdata[ABITS +: ROW_DELAY_BITS],
                          rsp_tdata[ABITS + ROW_DELAY_BITS]);
   end

   // overall time limit
   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic logic [15:0] rand16();
      return 16'($urandom);
   endfunction

   // random delays half the time, the rest extremes and tiny values that produce ties
   function automatic logic [DELAY_IN_BITS-1:0] rand_delay();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2, 3, 4: return DELAY_IN_BITS'($urandom_range(3));
         default: return rand16();
      endcase
   endfunction

   function automatic logic [ABITS-1:0] pick_gw(bit wide);
      if (wide && $urandom_range(2) == 0)
         return rand16();
      return addr_pool[$urandom_range(wide ? 15 : 3)];
   endfunction

   function automatic logic [ABITS-1:0] pick_dest(bit wide);
      if (wide && $urandom_range(2) == 0)
         return rand16();
      return addr_pool[$urandom_range(wide ? 15 : 7)];
   endfunction

   // offer one request word; entered and left at a falling edge
   task automatic send_word(func_type f, logic [ABITS-1:0] a,
                            logic [DELAY_IN_BITS-1:0] d, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tdata  <= REQ_W'({d, a});
      req_tuser  <= f;
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      store.note_word(f, a, d, last);
      if (f != FUNC_RSVD)
         words_sent++;
      @(negedge clock);
   endtask

   // header followed by a few entries, optionally closed by tlast
   task automatic send_packet(bit wide, bit closed);
      int n;
      n = $urandom_range(4);
      send_word(FUNC_HEADER, pick_gw(wide), rand_delay(), closed && n == 0);
      for (int k = 0; k < n; k++)
         send_word(FUNC_ENTRY, pick_dest(wide), rand_delay(), closed && k == n - 1);
   endtask

   // reserved words, orphan entries, unclosed packets, lookups with tlast
   task automatic send_noise(bit wide);
      case ($urandom_range(3))
         0: send_word(FUNC_RSVD, rand16(), rand16(), 1'($urandom_range(1)));
         1: send_word(FUNC_ENTRY, pick_dest(wide), rand_delay(), 1'($urandom_range(1)));
         2: send_packet(wide, 0);
         default: send_word(FUNC_LOOKUP, rand16(), rand16(), 1'b1);
      endcase
   endtask

   task automatic random_phase(int target, bit wide);
      int start;
      int pick;
      start = words_sent;
      while (words_sent - start < target) begin
         pick = $urandom_range(99);
         if (pick < 55)
            send_packet(wide, 1);
         else if (pick < 85)
            send_word(FUNC_LOOKUP, pick_dest(wide), rand_delay(), 1'($urandom_range(3) == 0));
         else
            send_noise(wide);
      end
      req_tvalid <= 1'b0;
   endtask

   // wait for the block to go idle, then write own address and new idling
   task automatic write_own(logic [ABITS-1:0] value, int send_pct, int stall_pct);
      while (store.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      store.own_addr = value;
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      reset      = 1'b1;
      req_tdata  = '0;
      req_tuser  = FUNC_HEADER;
      req_tlast  = 1'b0;
      req_tvalid = 1'b0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      addr_pool[0] = '0;
      addr_pool[1] = '1;
      for (int i = 2; i < 16; i++)
         addr_pool[i] = rand16();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty table, entry before any header, own address at reset value
      send_word(FUNC_LOOKUP, 16'h0000, 16'h0000, 1'b0);
      send_word(FUNC_ENTRY,  16'h0005, 16'h0007, 1'b1);
      send_word(FUNC_ENTRY,  16'h0000, 16'h0009, 1'b1);
      send_word(FUNC_RSVD,   16'hffff, 16'hffff, 1'b1);
      // largest link delay plus largest estimate
      send_word(FUNC_HEADER, 16'hffff, 16'hffff, 1'b0);
      send_word(FUNC_ENTRY,  16'h0005, 16'hffff, 1'b1);
      send_word(FUNC_LOOKUP, 16'h0005, 16'h0000, 1'b1);
      // two routes of equal delay to one destination
      send_word(FUNC_HEADER, 16'h0000, 16'h0007, 1'b0);
      send_word(FUNC_ENTRY,  16'h0005, 16'h0000, 1'b1);
      send_word(FUNC_HEADER, 16'h0003, 16'h0003, 1'b0);
      send_word(FUNC_ENTRY,  16'h0005, 16'h0004, 1'b1);
      send_word(FUNC_LOOKUP, 16'h0005, 16'hffff, 1'b0);
      send_word(FUNC_LOOKUP, 16'hffff, 16'h0000, 1'b0);
      send_word(FUNC_LOOKUP, 16'h1234, 16'h0000, 1'b1);
      req_tvalid <= 1'b0;

      // directed: header and entry naming the own address
      write_own(16'hffff, 0, 0);
      send_word(FUNC_HEADER, 16'hffff, 16'h0000, 1'b1);
      send_word(FUNC_ENTRY,  16'hffff, 16'h0005, 1'b1);
      send_word(FUNC_LOOKUP, 16'hffff, 16'h0000, 1'b0);
      send_word(FUNC_ENTRY,  16'h0000, 16'h0000, 1'b0);
      send_word(FUNC_RSVD,   16'h0000, 16'h0000, 1'b0);
      send_word(FUNC_ENTRY,  16'h0000, 16'h0001, 1'b1);
      send_word(FUNC_LOOKUP, 16'h0000, 16'h0000, 1'b0);
      req_tvalid <= 1'b0;

      // random traffic on a small address set, no idling
      write_own(addr_pool[2], 0, 0);
      random_phase(190, 0);

      // sender idles
      write_own(16'h0000, 66, 0);
      random_phase(190, 0);

      // receiver stalls; first a long hold-off while lookups keep coming
      write_own(rand16(), 0, 66);
      @(posedge clock);
      hold_cycles = HOLD_OFF_CYCLES;
      @(negedge clock);
      repeat (30) send_word(FUNC_LOOKUP, pick_dest(0), rand_delay(), 1'b0);
      random_phase(160, 0);

      // both sides idle, wide addresses fill the table and overflow it
      write_own(16'hffff, 12, 12);
      random_phase(190, 1);

      while (store.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (store.mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
